/* rtl/bpol_pkg.sv */
// ----------------------------------------------------------------------------
// bpol_pkg
// Request codes and result status codes of the bucket priority open list.
// ----------------------------------------------------------------------------
package bpol_pkg;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_TAKE     = 2'd1,
      REQ_QUERY    = 2'd2,
      REQ_RESERVED = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_LEVEL = 3'd3,
      ST_TAKEN     = 3'd4,
      ST_NONE_LEFT = 3'd5,
      ST_QUERY     = 3'd6,
      ST_UNUSED    = 3'd7
   } status_type;

endpackage

/* rtl/bpol_req_if.sv */
// ----------------------------------------------------------------------------
// bpol_req_if
// Request channel: valid/ready handshake with request type, level, key, payload.
// ----------------------------------------------------------------------------
interface bpol_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [5:0]  level;
   logic [31:0] entry_key;
   logic [31:0] entry_payload;

   modport source (output valid, req_type, level, entry_key, entry_payload, input ready);
   modport sink   (input valid, req_type, level, entry_key, entry_payload, output ready);
endinterface

/* rtl/bpol_rsp_if.sv */
// ----------------------------------------------------------------------------
// bpol_rsp_if
// Response channel: valid/ready handshake with status and returned entry.
// ----------------------------------------------------------------------------
interface bpol_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        found;
   logic [5:0]  out_level;
   logic [31:0] out_key;
   logic [31:0] out_payload;

   modport source (output valid, status, found, out_level, out_key, out_payload,
                   input ready);
   modport sink   (input valid, status, found, out_level, out_key, out_payload,
                   output ready);
endinterface

/* rtl/bpol_ram.sv */
// ----------------------------------------------------------------------------
// bpol_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/bucket_priority_open_list.sv */
// ----------------------------------------------------------------------------
// bucket_priority_open_list
// Open list for best-first search, one bucket of entries per score level.
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries one request per transaction: insert, take best
//   undeveloped, or query best. rsp_chan returns exactly one result per
//   request, in order. req_chan.ready is high only while the sequencer is
//   idle; one request is worked at a time.
// operation:
//   insert walks its bucket for duplicates, a RAM read then a compare per
//   stored entry.
//   take and query walk the per-level flag bits one level per cycle from the
//   top, then read the count RAM and the entry RAMs.
//   developed entries of a level always form a prefix, so take reads the
//   entry at the level's taken count directly.
// reset: all levels read as empty at once (per-level flag bits), no
//   clearing pass. a finished result waits in the output register while
//   the next request is accepted; a stalled receiver holds the sequencer
//   in its last state until the output register frees up.
// ----------------------------------------------------------------------------
module bucket_priority_open_list
   import bpol_pkg::*;
#(
   parameter int NUM_LEVELS      = 64,
   parameter int BUCKET_CAPACITY = 32,
   parameter int KEY_WIDTH       = 32,
   parameter int PAYLOAD_WIDTH   = 32
) (
   input  logic       clock,
   input  logic       reset,
   bpol_req_if.sink   req_chan,
   bpol_rsp_if.source rsp_chan
);
   localparam int SLOTS = NUM_LEVELS * BUCKET_CAPACITY;
   localparam int AW    = $clog2(SLOTS);
   localparam int LW    = $clog2(NUM_LEVELS);
   localparam int CW    = $clog2(BUCKET_CAPACITY + 1);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_SCAN    = 10'b00_0000_0010,
      S_CNT_RD  = 10'b00_0000_0100,
      S_CNT_USE = 10'b00_0000_1000,
      S_DUP_RD  = 10'b00_0001_0000,
      S_DUP_CMP = 10'b00_0010_0000,
      S_WRITE   = 10'b00_0100_0000,
      S_ENT_RD  = 10'b00_1000_0000,
      S_ENT_USE = 10'b01_0000_0000,
      S_RESP    = 10'b10_0000_0000
   } state_type;

   function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] lvl, logic [CW-1:0] idx);
      return AW'(AW'(lvl) * AW'(BUCKET_CAPACITY) + AW'(idx));
   endfunction

   state_type          state_ff, state_in;
   req_code_type       op_ff, op_in;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [CW-1:0]      idx_ff, idx_in, n_ff, n_in, t_ff, t_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in, undev_ff, undev_in;

   status_type         st_ff, st_in;
   logic               fnd_ff, fnd_in;
   logic [5:0]         olvl_ff, olvl_in;
   logic [31:0]        okey_ff, okey_in, opay_ff, opay_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_st_ff, rsp_st_in;
   logic               rsp_fnd_ff, rsp_fnd_in;
   logic [5:0]         rsp_lvl_ff, rsp_lvl_in;
   logic [31:0]        rsp_key_ff, rsp_key_in, rsp_pay_ff, rsp_pay_in;

   logic                     ent_we, ctr_we;
   logic [AW-1:0]            ent_waddr;
   logic [2*CW-1:0]          ctr_wdata, ctr_rdata;
   logic [KEY_WIDTH-1:0]     key_rdata;
   logic [PAYLOAD_WIDTH-1:0] pay_rdata;
   logic                     req_fire, flag_hit;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign flag_hit       = (op_ff == REQ_TAKE) ? undev_ff[lvl_ff] : nonempty_ff[lvl_ff];

   bpol_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOTS)) u_key_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(key_ff),
      .rd_addr(slot_addr(lvl_ff, idx_ff)), .rd_data(key_rdata)
   );

   bpol_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(SLOTS)) u_pay_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(pay_ff),
      .rd_addr(slot_addr(lvl_ff, idx_ff)), .rd_data(pay_rdata)
   );

   // per level: {entry count, taken count}
   bpol_ram #(.WIDTH(2 * CW), .DEPTH(NUM_LEVELS)) u_ctr_ram (
      .clock(clock), .wr_en(ctr_we), .wr_addr(lvl_ff), .wr_data(ctr_wdata),
      .rd_addr(lvl_ff), .rd_data(ctr_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      lvl_in      = lvl_ff;
      key_in      = key_ff;
      pay_in      = pay_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      t_in        = t_ff;
      nonempty_in = nonempty_ff;
      undev_in    = undev_ff;
      st_in       = st_ff;
      fnd_in      = fnd_ff;
      olvl_in     = olvl_ff;
      okey_in     = okey_ff;
      opay_in     = opay_ff;
      ent_we      = 1'b0;
      ent_waddr   = slot_addr(lvl_ff, n_ff);
      ctr_we      = 1'b0;
      ctr_wdata   = {n_ff, t_ff};

      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_fnd_in   = rsp_fnd_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_code_type'(req_chan.req_type);
               key_in  = KEY_WIDTH'(req_chan.entry_key);
               pay_in  = PAYLOAD_WIDTH'(req_chan.entry_payload);
               fnd_in  = 1'b0;
               olvl_in = '0;
               okey_in = '0;
               opay_in = '0;
               if (req_code_type'(req_chan.req_type) == REQ_INSERT) begin
                  lvl_in = LW'(req_chan.level);
                  if (32'(req_chan.level) >= 32'(NUM_LEVELS)) begin
                     st_in    = ST_BAD_LEVEL;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_CNT_RD;
                  end
               end else begin
                  lvl_in   = LW'(NUM_LEVELS - 1);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (flag_hit) begin
               state_in = S_CNT_RD;
            end else if (lvl_ff == '0) begin
               st_in    = (op_ff == REQ_TAKE) ? ST_NONE_LEFT : ST_QUERY;
               state_in = S_RESP;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_USE;
         end
         S_CNT_USE: begin
            // a level never written reads as empty
            n_in   = nonempty_ff[lvl_ff] ? ctr_rdata[2*CW-1:CW] : '0;
            t_in   = nonempty_ff[lvl_ff] ? ctr_rdata[CW-1:0] : '0;
            idx_in = '0;
            case (op_ff)
               REQ_INSERT: state_in = nonempty_ff[lvl_ff] ? S_DUP_RD : S_WRITE;
               REQ_TAKE: begin
                  idx_in   = ctr_rdata[CW-1:0];
                  state_in = S_ENT_RD;
               end
               default: state_in = S_ENT_RD;
            endcase
         end
         S_DUP_RD: begin
            state_in = S_DUP_CMP;
         end
         S_DUP_CMP: begin
            if (key_rdata == key_ff) begin
               st_in    = ST_DUPLICATE;
               state_in = S_RESP;
            end else if (idx_ff + 1'b1 == n_ff) begin
               state_in = S_WRITE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DUP_RD;
            end
         end
         S_WRITE: begin
            if (n_ff >= CW'(BUCKET_CAPACITY)) begin
               st_in = ST_FULL;
            end else begin
               ent_we              = 1'b1;
               ctr_we              = 1'b1;
               ctr_wdata           = {CW'(n_ff + 1'b1), t_ff};
               nonempty_in[lvl_ff] = 1'b1;
               undev_in[lvl_ff]    = 1'b1;
               st_in               = ST_INSERTED;
            end
            state_in = S_RESP;
         end
         S_ENT_RD: begin
            state_in = S_ENT_USE;
         end
         S_ENT_USE: begin
            fnd_in  = 1'b1;
            olvl_in = 6'(lvl_ff);
            okey_in = 32'(key_rdata);
            opay_in = 32'(pay_rdata);
            if (op_ff == REQ_TAKE) begin
               st_in     = ST_TAKEN;
               ctr_we    = 1'b1;
               ctr_wdata = {n_ff, CW'(t_ff + 1'b1)};
               if (CW'(t_ff + 1'b1) == n_ff) begin
                  undev_in[lvl_ff] = 1'b0;
               end
            end else begin
               st_in = ST_QUERY;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = st_ff;
               rsp_fnd_in   = fnd_ff;
               rsp_lvl_in   = olvl_ff;
               rsp_key_in   = okey_ff;
               rsp_pay_in   = opay_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         undev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         undev_ff     <= undev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      lvl_ff     <= lvl_in;
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      t_ff       <= t_in;
      st_ff      <= st_in;
      fnd_ff     <= fnd_in;
      olvl_ff    <= olvl_in;
      okey_ff    <= okey_in;
      opay_ff    <= opay_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_fnd_ff <= rsp_fnd_in;
      rsp_lvl_ff <= rsp_lvl_in;
      rsp_key_ff <= rsp_key_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_st_ff;
   assign rsp_chan.found       = rsp_fnd_ff;
   assign rsp_chan.out_level   = rsp_lvl_ff;
   assign rsp_chan.out_key     = rsp_key_ff;
   assign rsp_chan.out_payload = rsp_pay_ff;

   // a new result only comes out of the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response produced outside response state");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fnd_ff) |-> (rsp_st_ff == ST_TAKEN || rsp_st_ff == ST_QUERY))
      else $error("found set on a status that returns nothing");

   // an undeveloped level must also be non-empty
   a_undev_subset: assert property (@(posedge clock) disable iff (reset)
      (undev_ff & ~nonempty_ff) == '0)
      else $error("undeveloped flag on an empty level");

   a_taken_le_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENT_RD && op_ff == REQ_TAKE) |-> (t_ff < n_ff))
      else $error("take reading past the bucket count");
endmodule
